FILE: hdl/rkmc_pkg.sv
package rkmc_pkg;

  // Field widths
  localparam int COORD_W   = 24;
  localparam int RANGE_W   = 25;
  localparam int WEIGHT_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Derived datapath widths
  localparam int DIFF_W    = COORD_W;           // |a - b| of two coordinates
  localparam int SQ_W      = 2 * DIFF_W;        // one square
  localparam int SUM_W     = SQ_W + 1;          // sum of two squares
  localparam int ROOT_W    = COORD_W + 1;       // root of the padded radicand
  localparam int RAD_W     = 2 * ROOT_W;        // radicand, even number of bits
  localparam int REM_W     = ROOT_W + 2;        // square root remainder
  localparam int NUM_W     = WEIGHT_W + RANGE_W;
  localparam int Q_W       = WEIGHT_W;

  // Iteration counts of the two loops
  localparam int SQRT_ITER = ROOT_W;
  localparam int DIV_ITER  = Q_W;
  localparam int LOOP_MAX  = ((SQRT_ITER > DIV_ITER) ? SQRT_ITER : DIV_ITER) - 1;
  localparam int LOOP_W    = $clog2(LOOP_MAX + 1);

  // Program counter
  localparam int PC_W = 4;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_CHASE  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_MIN = 2'd0,
    REG_RANGE_MAX = 2'd1,
    REG_HALFWAY   = 2'd2,
    REG_WEIGHT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] own_x;
    logic signed [COORD_W-1:0] own_y;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
  } in_t;

  typedef struct packed {
    mode_t                mode;
    logic                 active;
    logic [RANGE_W-1:0]   range;
    logic [WEIGHT_W-1:0]  priority_res;
  } out_t;

  typedef struct packed {
    logic [RANGE_W-1:0]  lo_bound;
    logic [RANGE_W-1:0]  hi_bound;
    logic                halfway_enable;
    logic [WEIGHT_W-1:0] priority_weight;
  } cfg_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_X,
    OP_ACC_LOAD,
    OP_MUL_Y,
    OP_ACC_ADD,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_RANGE,
    OP_MODE,
    OP_PMUL,
    OP_PCHK,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_OUT
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    J_NONE,
    J_ALWAYS,
    J_NO_INPUT,
    J_LOOP,
    J_PRI_DONE,
    J_OUT_FULL
  } cond_t;

  // Loop counter loads
  typedef enum logic [1:0] {
    CNT_NONE,
    CNT_SQRT,
    CNT_DIV
  } cnt_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    cnt_t            cnt;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic pri_done;
  } stat_t;

  // Step addresses
  localparam logic [PC_W-1:0] S_WAIT = 4'd0;
  localparam logic [PC_W-1:0] S_MULX = 4'd1;
  localparam logic [PC_W-1:0] S_ACCX = 4'd2;
  localparam logic [PC_W-1:0] S_MULY = 4'd3;
  localparam logic [PC_W-1:0] S_ACCY = 4'd4;
  localparam logic [PC_W-1:0] S_SQI  = 4'd5;
  localparam logic [PC_W-1:0] S_SQS  = 4'd6;
  localparam logic [PC_W-1:0] S_RNG  = 4'd7;
  localparam logic [PC_W-1:0] S_MODE = 4'd8;
  localparam logic [PC_W-1:0] S_PMUL = 4'd9;
  localparam logic [PC_W-1:0] S_PCHK = 4'd10;
  localparam logic [PC_W-1:0] S_PBR  = 4'd11;
  localparam logic [PC_W-1:0] S_DIV  = 4'd12;
  localparam logic [PC_W-1:0] S_DEND = 4'd13;
  localparam logic [PC_W-1:0] S_OUT  = 4'd14;
  localparam logic [PC_W-1:0] S_BACK = 4'd15;

  // Microcode ROM: a true condition jumps to target, otherwise the next step
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      S_WAIT: w = '{op: OP_LOAD,      cond: J_NO_INPUT, cnt: CNT_NONE, target: S_WAIT};
      S_MULX: w = '{op: OP_MUL_X,     cond: J_NONE,     cnt: CNT_NONE, target: S_WAIT};
      S_ACCX: w = '{op: OP_ACC_LOAD,  cond: J_NONE,     cnt: CNT_NONE, target: S_WAIT};
      S_MULY: w = '{op: OP_MUL_Y,     cond: J_NONE,     cnt: CNT_NONE, target: S_WAIT};
      S_ACCY: w = '{op: OP_ACC_ADD,   cond: J_NONE,     cnt: CNT_NONE, target: S_WAIT};
      S_SQI:  w = '{op: OP_SQRT_INIT, cond: J_NONE,     cnt: CNT_SQRT, target: S_WAIT};
      S_SQS:  w = '{op: OP_SQRT_STEP, cond: J_LOOP,     cnt: CNT_NONE, target: S_SQS};
      S_RNG:  w = '{op: OP_RANGE,     cond: J_NONE,     cnt: CNT_NONE, target: S_WAIT};
      S_MODE: w = '{op: OP_MODE,      cond: J_NONE,     cnt: CNT_NONE, target: S_WAIT};
      S_PMUL: w = '{op: OP_PMUL,      cond: J_NONE,     cnt: CNT_NONE, target: S_WAIT};
      S_PCHK: w = '{op: OP_PCHK,      cond: J_NONE,     cnt: CNT_DIV,  target: S_WAIT};
      S_PBR:  w = '{op: OP_NONE,      cond: J_PRI_DONE, cnt: CNT_NONE, target: S_OUT};
      S_DIV:  w = '{op: OP_DIV_STEP,  cond: J_LOOP,     cnt: CNT_NONE, target: S_DIV};
      S_DEND: w = '{op: OP_DIV_END,   cond: J_NONE,     cnt: CNT_NONE, target: S_WAIT};
      S_OUT:  w = '{op: OP_OUT,       cond: J_OUT_FULL, cnt: CNT_NONE, target: S_OUT};
      S_BACK: w = '{op: OP_NONE,      cond: J_ALWAYS,   cnt: CNT_NONE, target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/range_keeping_mode_controller_top.sv
// Channel | Signals                                   | Transfer when
// --------+-------------------------------------------+------------------------
// in      | in_valid, in_stall, in_data (in_t)        | in_valid && !in_stall
// out     | out_valid, out_stall, out_data (out_t)    | out_valid && !out_stall
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// One item at a time: the input stays stalled from transfer until the sequencer is
// back at its wait step. How long that takes is set by the 25-step square root loop
// and, when the priority needs a divide, the 16-step divide loop of the sequencer.
// Synchronous reset clears the sequencer, the output flag, the held mode and the
// configuration registers to their reset values. An output stall holds the sequencer at the
// output step only while the previous result is still waiting.
module range_keeping_mode_controller_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rkmc_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rkmc_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rkmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rkmc_pkg::RANGE_W-1:0]     cfg_data
);

  // Sequencer state
  logic [rkmc_pkg::PC_W-1:0]   pc;
  logic [rkmc_pkg::PC_W-1:0]   pc_next;
  logic [rkmc_pkg::LOOP_W-1:0] cnt;
  logic [rkmc_pkg::LOOP_W-1:0] cnt_next;
  logic                        out_full;

  rkmc_pkg::ctrl_t word;
  rkmc_pkg::op_t   op_eff;
  rkmc_pkg::cfg_t  cfg;
  rkmc_pkg::out_t  res;
  rkmc_pkg::stat_t status;
  logic            hold;
  logic            take;
  logic            out_xfer;

  assign word      = rkmc_pkg::ucode(pc);
  assign in_stall  = (pc != rkmc_pkg::S_WAIT);
  assign out_valid = out_full;
  assign out_xfer  = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  // Waiting steps do no work
  assign hold   = (word.cond == rkmc_pkg::J_NO_INPUT && !in_valid) ||
                  (word.cond == rkmc_pkg::J_OUT_FULL && out_full);
  assign op_eff = hold ? rkmc_pkg::OP_NONE : word.op;

  // Jump decision
  always_comb begin
    unique case (word.cond)
      rkmc_pkg::J_NONE:     take = 1'b0;
      rkmc_pkg::J_ALWAYS:   take = 1'b1;
      rkmc_pkg::J_NO_INPUT: take = !in_valid;
      rkmc_pkg::J_LOOP:     take = (cnt != '0);
      rkmc_pkg::J_PRI_DONE: take = status.pri_done;
      rkmc_pkg::J_OUT_FULL: take = out_full;
      default:              take = 1'b0;
    endcase
    pc_next = take ? word.target : pc + 1'b1;
  end

  // Loop counter
  always_comb begin
    unique case (word.cnt)
      rkmc_pkg::CNT_SQRT: cnt_next = rkmc_pkg::LOOP_W'(rkmc_pkg::SQRT_ITER - 1);
      rkmc_pkg::CNT_DIV:  cnt_next = rkmc_pkg::LOOP_W'(rkmc_pkg::DIV_ITER - 1);
      default: begin
        if (word.cond == rkmc_pkg::J_LOOP && cnt != '0) begin
          cnt_next = cnt - 1'b1;
        end else begin
          cnt_next = cnt;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= rkmc_pkg::S_WAIT;
      cnt      <= '0;
      out_full <= 1'b0;
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
      if (op_eff == rkmc_pkg::OP_OUT) begin
        out_full <= 1'b1;
      end else if (out_xfer) begin
        out_full <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (op_eff == rkmc_pkg::OP_OUT) begin
      out_data <= res;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lo_bound        <= '0;
      cfg.hi_bound        <= '0;
      cfg.halfway_enable  <= 1'b1;
      cfg.priority_weight <= rkmc_pkg::WEIGHT_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rkmc_pkg::REG_RANGE_MIN: cfg.lo_bound        <= cfg_data;
        rkmc_pkg::REG_RANGE_MAX: cfg.hi_bound        <= cfg_data;
        rkmc_pkg::REG_HALFWAY:   cfg.halfway_enable  <= cfg_data[0];
        rkmc_pkg::REG_WEIGHT:    cfg.priority_weight <= cfg_data[rkmc_pkg::WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rkmc_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .op      (op_eff),
    .cfg     (cfg),
    .in_data (in_data),
    .res     (res),
    .status  (status)
  );

endmodule

FILE: hdl/rkmc_datapath.sv
module rkmc_datapath (
  input  logic           clk,
  input  logic           rst,
  input  rkmc_pkg::op_t  op,
  input  rkmc_pkg::cfg_t cfg,
  input  rkmc_pkg::in_t  in_data,
  output rkmc_pkg::out_t res,
  output rkmc_pkg::stat_t status
);

  localparam int CW     = rkmc_pkg::COORD_W;
  localparam int CMP_W  = (rkmc_pkg::ROOT_W > rkmc_pkg::RANGE_W) ?
                          rkmc_pkg::ROOT_W : rkmc_pkg::RANGE_W;
  localparam logic [rkmc_pkg::RANGE_W-1:0] RANGE_ALL = '1;

  // Payload registers
  logic [rkmc_pkg::DIFF_W-1:0]   dx;
  logic [rkmc_pkg::DIFF_W-1:0]   dy;
  logic [rkmc_pkg::SQ_W-1:0]     prod;
  logic [rkmc_pkg::SUM_W-1:0]    acc;
  logic [rkmc_pkg::RAD_W-1:0]    rad;
  logic [rkmc_pkg::REM_W-1:0]    srem;
  logic [rkmc_pkg::ROOT_W-1:0]   root;
  logic [rkmc_pkg::RANGE_W-1:0]  rng;
  logic [rkmc_pkg::RANGE_W-1:0]  diff;
  logic [rkmc_pkg::NUM_W-1:0]    num;
  logic [rkmc_pkg::NUM_W-1:0]    drem;
  logic [rkmc_pkg::NUM_W-1:0]    dsh;
  logic [rkmc_pkg::Q_W-1:0]      quo;
  logic [rkmc_pkg::WEIGHT_W-1:0] pri;

  // Control state
  rkmc_pkg::mode_t cur_mode;
  logic            pri_done;

  // Coordinate differences
  logic signed [CW:0] dxs;
  logic signed [CW:0] dys;
  logic [rkmc_pkg::DIFF_W-1:0] mul_a;

  // Square root step
  logic [rkmc_pkg::REM_W-1:0] cand;
  logic [rkmc_pkg::REM_W-1:0] trial;

  // Mode and priority
  logic [rkmc_pkg::RANGE_W:0]   twice_mark;
  logic [rkmc_pkg::RANGE_W:0]   twice_rng;
  rkmc_pkg::mode_t              mode_next;
  logic [rkmc_pkg::RANGE_W-1:0] den;
  logic [rkmc_pkg::NUM_W-1:0]   den_full;

  always_comb begin
    dxs = {in_data.target_x[CW-1], in_data.target_x} - {in_data.own_x[CW-1], in_data.own_x};
    dys = {in_data.target_y[CW-1], in_data.target_y} - {in_data.own_y[CW-1], in_data.own_y};
  end

  assign mul_a = (op == rkmc_pkg::OP_MUL_Y) ? dy : dx;

  assign cand  = {srem[rkmc_pkg::REM_W-3:0], rad[rkmc_pkg::RAD_W-1 -: 2]};
  assign trial = {root, 2'b01};

  assign twice_mark = {1'b0, cfg.lo_bound} + {1'b0, cfg.hi_bound};
  assign twice_rng  = {rng, 1'b0};

  // Next mode from range and held mode
  always_comb begin
    if (!cfg.halfway_enable && rng >= cfg.lo_bound && rng <= cfg.hi_bound) begin
      mode_next = rkmc_pkg::MODE_IDLE;
    end else if (cfg.halfway_enable &&
                 ((twice_rng > twice_mark && cur_mode == rkmc_pkg::MODE_ESCAPE) ||
                  (twice_rng < twice_mark && cur_mode == rkmc_pkg::MODE_CHASE))) begin
      mode_next = rkmc_pkg::MODE_IDLE;
    end else if (rng < cfg.lo_bound || cur_mode == rkmc_pkg::MODE_ESCAPE) begin
      mode_next = rkmc_pkg::MODE_ESCAPE;
    end else if (rng > cfg.hi_bound || cur_mode == rkmc_pkg::MODE_CHASE) begin
      mode_next = rkmc_pkg::MODE_CHASE;
    end else begin
      mode_next = rkmc_pkg::MODE_IDLE;
    end
  end

  // Band width; only used when the upper bound is above the lower one
  assign den      = cfg.hi_bound - cfg.lo_bound;
  assign den_full = {den, {rkmc_pkg::Q_W{1'b0}}};

  // Held mode and priority-settled flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode <= rkmc_pkg::MODE_IDLE;
      pri_done <= 1'b0;
    end else begin
      if (op == rkmc_pkg::OP_MODE) begin
        cur_mode <= mode_next;
      end
      if (op == rkmc_pkg::OP_PCHK) begin
        pri_done <= (cur_mode == rkmc_pkg::MODE_IDLE) || (rng > cfg.hi_bound) ||
                    (cfg.hi_bound == cfg.lo_bound) || (num == '0) ||
                    (cfg.hi_bound < cfg.lo_bound) || (num >= den_full);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (op)
      rkmc_pkg::OP_LOAD: begin
        dx <= dxs[CW] ? rkmc_pkg::DIFF_W'(-dxs) : rkmc_pkg::DIFF_W'(dxs);
        dy <= dys[CW] ? rkmc_pkg::DIFF_W'(-dys) : rkmc_pkg::DIFF_W'(dys);
      end
      rkmc_pkg::OP_MUL_X, rkmc_pkg::OP_MUL_Y: begin
        prod <= mul_a * mul_a;
      end
      rkmc_pkg::OP_ACC_LOAD: begin
        acc <= rkmc_pkg::SUM_W'(prod);
      end
      rkmc_pkg::OP_ACC_ADD: begin
        acc <= acc + rkmc_pkg::SUM_W'(prod);
      end
      rkmc_pkg::OP_SQRT_INIT: begin
        rad  <= rkmc_pkg::RAD_W'(acc);
        srem <= '0;
        root <= '0;
      end
      // One root bit per step
      rkmc_pkg::OP_SQRT_STEP: begin
        rad <= {rad[rkmc_pkg::RAD_W-3:0], 2'b00};
        if (cand >= trial) begin
          srem <= cand - trial;
          root <= {root[rkmc_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          srem <= cand;
          root <= {root[rkmc_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      // Saturate the root to the range field
      rkmc_pkg::OP_RANGE: begin
        rng <= (CMP_W'(root) > CMP_W'(RANGE_ALL)) ? RANGE_ALL :
               rkmc_pkg::RANGE_W'(root);
      end
      rkmc_pkg::OP_MODE: begin
        diff <= cfg.hi_bound - rng;
      end
      rkmc_pkg::OP_PMUL: begin
        num <= cfg.priority_weight * diff;
      end
      // Settle the special cases, or set up the divide
      rkmc_pkg::OP_PCHK: begin
        drem <= num;
        dsh  <= rkmc_pkg::NUM_W'({den, {(rkmc_pkg::Q_W-1){1'b0}}});
        quo  <= '0;
        if (cur_mode == rkmc_pkg::MODE_IDLE) begin
          pri <= '0;
        end else if (rng > cfg.hi_bound || cfg.hi_bound == cfg.lo_bound) begin
          pri <= cfg.priority_weight;
        end else if (num == '0 || cfg.hi_bound < cfg.lo_bound) begin
          pri <= '0;
        end else if (num >= den_full) begin
          pri <= '1;
        end
      end
      // Restoring divide, one quotient bit per step
      rkmc_pkg::OP_DIV_STEP: begin
        dsh <= dsh >> 1;
        if (drem >= dsh) begin
          drem <= drem - dsh;
          quo  <= {quo[rkmc_pkg::Q_W-2:0], 1'b1};
        end else begin
          quo  <= {quo[rkmc_pkg::Q_W-2:0], 1'b0};
        end
      end
      rkmc_pkg::OP_DIV_END: begin
        pri <= quo;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.mode         = cur_mode;
    res.active       = (cur_mode != rkmc_pkg::MODE_IDLE);
    res.range        = rng;
    res.priority_res = pri;
  end

  assign status.pri_done = pri_done;

endmodule
